[hdl/rast_pkg.sv]
// ----------------------------------------------------------------------------
// rast_pkg
// Types and constants shared by the line segment rasterizer modules.
// ----------------------------------------------------------------------------
package rast_pkg;

    localparam int MAP_SIZE = 256;
    localparam int DEN      = 51200;
    localparam int OFFSET   = 25600;
    localparam int PW       = 27;
    localparam int QW       = 10;
    localparam int CW       = 12;
    localparam int MW       = 10;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    typedef struct packed {
        logic signed [15:0] start_x;
        logic signed [15:0] start_z;
        logic signed [15:0] end_x;
        logic signed [15:0] end_z;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pixel_addr_a;
        logic [15:0] pixel_addr_b;
        logic [15:0] pixel_addr_c;
        logic [15:0] pixel_addr_d;
        logic [2:0]  valid_count;
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic        last_of_line;
    } t_out_item;

    typedef struct packed {
        logic                 major_z;
        logic signed [PW-1:0] len;
        logic signed [PW-1:0] minor;
        logic signed [CW-1:0] col;
        logic signed [CW-1:0] row;
        t_color               color;
    } t_seg;

endpackage

[hdl/rast_setup.sv]
// ----------------------------------------------------------------------------
// rast_setup
// Front end: maps segment ends to map pixels, orders them and picks the walk.
// ----------------------------------------------------------------------------
module rast_setup (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  rast_pkg::t_in_item i_item,
    input  logic [rast_pkg::MW-1:0] i_map_w,
    output logic              o_seg_valid,
    input  logic              i_seg_ready,
    output rast_pkg::t_seg    o_seg
);
    import rast_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_ABS   = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_ORDER = 7'b0010000,
        S_CLASS = 7'b0100000,
        S_PUSH  = 7'b1000000
    } t_setup_state;

    // divide by DEN as a shift by DSH, then a reciprocal multiply for the 25
    localparam int DSH   = 11;
    localparam int RECIP = 5243;
    localparam int RSH   = 17;

    t_setup_state         r_state;
    t_in_item             r_item;
    logic signed [PW-1:0] r_p [4];
    logic [PW-2:0]        r_rem [4];
    logic                 r_neg [4];
    logic [QW-1:0]        r_q [4];
    logic signed [PW-1:0] r_ddx;
    logic signed [PW-1:0] r_ddz;
    logic signed [CW-1:0] r_qsx, r_qsz, r_qex, r_qez;
    t_seg                 r_seg;

    logic signed [15:0]   w_w [4];
    logic signed [16:0]   w_off [4];
    logic signed [27:0]   w_prod [4];
    logic [27:0]          w_quo [4];
    logic signed [CW-1:0] w_qs [4];
    logic                 w_swap;
    logic signed [CW-1:0] w_lo, w_hi, w_diff;
    t_seg                 w_seg;

    assign o_full      = (r_state != S_IDLE);
    assign o_seg_valid = (r_state == S_PUSH);
    assign o_seg       = r_seg;

    assign w_w[0] = r_item.start_x;
    assign w_w[1] = r_item.start_z;
    assign w_w[2] = r_item.end_x;
    assign w_w[3] = r_item.end_z;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_off[k]  = 17'(w_w[k]) + 17'(OFFSET);
            w_prod[k] = w_off[k] * $signed({1'b0, i_map_w});
            w_quo[k]  = 28'(r_rem[k][PW-2:DSH]) * 28'(RECIP);
            w_qs[k]   = r_neg[k] ? -$signed(CW'(r_q[k])) : $signed(CW'(r_q[k]));
        end
        w_swap = r_p[2] < r_p[0];
    end

    always_comb begin
        w_lo   = (r_ddz > 0) ? r_qsz : r_qez;
        w_hi   = (r_ddz > 0) ? r_qez : r_qsz;
        w_diff = w_hi - w_lo;
        w_seg.color = t_color'({r_item.red_in, r_item.green_in, r_item.blue_in});
        if (r_ddx == '0) begin
            w_seg.major_z = 1'b1;
            w_seg.len     = PW'(32'(w_diff) * DEN);
            w_seg.minor   = '0;
            w_seg.col     = r_qex;
            w_seg.row     = w_lo;
        end else if (r_ddz < r_ddx && r_ddz >= -r_ddx) begin
            w_seg.major_z = 1'b0;
            w_seg.len     = r_ddx;
            w_seg.minor   = r_ddz;
            w_seg.col     = r_qsx;
            w_seg.row     = r_qsz;
        end else if (r_ddz < 0) begin
            w_seg.major_z = 1'b1;
            w_seg.len     = -r_ddz;
            w_seg.minor   = -r_ddx;
            w_seg.col     = r_qex;
            w_seg.row     = r_qez;
        end else begin
            w_seg.major_z = 1'b1;
            w_seg.len     = r_ddz;
            w_seg.minor   = r_ddx;
            w_seg.col     = r_qsx;
            w_seg.row     = r_qsz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_push) begin
                        r_item  <= i_item;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    for (int k = 0; k < 4; k++) begin
                        r_p[k] <= w_prod[k][PW-1:0];
                    end
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    for (int k = 0; k < 4; k++) begin
                        r_neg[k] <= r_p[k][PW-1];
                        r_rem[k] <= (PW-1)'(r_p[k][PW-1] ? -r_p[k] : r_p[k]);
                    end
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    for (int k = 0; k < 4; k++) begin
                        r_q[k] <= w_quo[k][RSH +: QW];
                    end
                    r_state <= S_ORDER;
                end
                S_ORDER: begin
                    if (w_swap) begin
                        r_ddx <= r_p[0] - r_p[2];
                        r_ddz <= r_p[1] - r_p[3];
                        r_qsx <= w_qs[2];
                        r_qsz <= w_qs[3];
                        r_qex <= w_qs[0];
                        r_qez <= w_qs[1];
                    end else begin
                        r_ddx <= r_p[2] - r_p[0];
                        r_ddz <= r_p[3] - r_p[1];
                        r_qsx <= w_qs[0];
                        r_qsz <= w_qs[1];
                        r_qex <= w_qs[2];
                        r_qez <= w_qs[3];
                    end
                    r_state <= S_CLASS;
                end
                S_CLASS: begin
                    r_seg   <= w_seg;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (i_seg_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[hdl/rast_fifo.sv]
// ----------------------------------------------------------------------------
// rast_fifo
// Two-entry queue of classified segments between setup and walker.
// ----------------------------------------------------------------------------
module rast_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rast_pkg::t_seg i_data,
    output logic           o_full,
    input  logic           i_pop,
    output rast_pkg::t_seg o_data,
    output logic           o_empty
);
    import rast_pkg::*;

    t_seg       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_wr;
    logic       w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

endmodule

[hdl/rast_walk.sv]
// ----------------------------------------------------------------------------
// rast_walk
// Back end: walks one segment a pixel per cycle, unless a full group waits on the output, and packs addresses.
// ----------------------------------------------------------------------------
module rast_walk #(
    parameter int WPR = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_seg_valid,
    output logic              o_seg_pop,
    input  rast_pkg::t_seg    i_seg,
    input  logic [rast_pkg::MW-1:0] i_map_w,
    output logic              o_empty,
    input  logic              i_pop,
    output rast_pkg::t_out_item o_result
);
    import rast_pkg::*;

    localparam int PIX_CAP = 64 * WPR;
    localparam int PCW     = $clog2(PIX_CAP + 1);
    localparam int CNTW    = $clog2(WPR + 1);

    typedef enum logic [1:0] {
        W_IDLE = 2'b01,
        W_WALK = 2'b10
    } t_walk_state;

    t_walk_state          r_state, n_state;
    logic                 r_major_z, n_major_z;
    logic signed [PW-1:0] r_len, n_len;
    logic                 r_neg, n_neg;
    logic [PW-2:0]        r_abs, n_abs;
    logic signed [CW-1:0] r_col, n_col;
    logic signed [CW-1:0] r_row, n_row;
    t_color               r_color, n_color;
    logic [PW-1:0]        r_acc, n_acc;
    logic [PW-1:0]        r_rem, n_rem;
    logic [PCW-1:0]       r_pix, n_pix;
    logic [CNTW-1:0]      r_cnt, n_cnt;
    logic [15:0]          r_slot [4];
    logic [15:0]          n_slot [4];
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;

    logic signed [CW-1:0] w_w;
    logic                 w_in_map;
    logic                 w_run;
    logic [2*MW-1:0]      w_lin;
    logic [15:0]          w_addr;
    logic [PW-1:0]        w_sum;
    logic                 w_carry;
    logic                 w_full_grp;
    logic                 w_out_free;
    logic                 w_push;
    logic                 w_adv;
    logic                 w_last;
    logic signed [CW-1:0] w_step;

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    always_comb begin
        w_w        = $signed(CW'(i_map_w));
        w_in_map   = (r_col >= 0) && (r_row >= 0) && (r_col < w_w) && (r_row < w_w);
        w_run      = ($signed({1'b0, r_acc}) < r_len) && (32'(r_pix) != PIX_CAP) && w_in_map;
        w_lin      = r_row[MW-1:0] * i_map_w + (2*MW)'(r_col[MW-1:0]);
        w_addr     = w_lin[15:0];
        w_sum      = r_rem + {1'b0, r_abs};
        w_carry    = $signed({1'b0, w_sum}) >= r_len;
        w_full_grp = (32'(r_cnt) == WPR);
        w_out_free = !r_out_valid || i_pop;
        w_step     = r_neg ? -CW'(1) : CW'(1);
    end

    always_comb begin
        n_state     = r_state;
        n_major_z   = r_major_z;
        n_len       = r_len;
        n_neg       = r_neg;
        n_abs       = r_abs;
        n_col       = r_col;
        n_row       = r_row;
        n_color     = r_color;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_pix       = r_pix;
        n_cnt       = r_cnt;
        n_slot      = r_slot;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_seg_pop   = 1'b0;
        w_push      = 1'b0;
        w_adv       = 1'b0;
        w_last      = 1'b0;

        unique case (r_state)
            W_IDLE: begin
                if (i_seg_valid) begin
                    o_seg_pop = 1'b1;
                    n_major_z = i_seg.major_z;
                    n_len     = i_seg.len;
                    n_neg     = i_seg.minor[PW-1];
                    n_abs     = (PW-1)'(i_seg.minor[PW-1] ? -i_seg.minor : i_seg.minor);
                    n_col     = i_seg.col;
                    n_row     = i_seg.row;
                    n_color   = i_seg.color;
                    n_acc     = '0;
                    n_rem     = '0;
                    n_pix     = '0;
                    n_cnt     = '0;
                    for (int j = 0; j < 4; j++) begin
                        n_slot[j] = '0;
                    end
                    n_state   = W_WALK;
                end
            end
            W_WALK: begin
                if (w_run) begin
                    if (w_full_grp) begin
                        if (w_out_free) begin
                            w_push = 1'b1;
                            w_adv  = 1'b1;
                            for (int j = 0; j < 4; j++) begin
                                n_slot[j] = '0;
                            end
                            n_slot[0] = w_addr;
                            n_cnt     = CNTW'(1);
                        end
                    end else begin
                        w_adv = 1'b1;
                        for (int j = 0; j < 4; j++) begin
                            if (32'(r_cnt) == j) begin
                                n_slot[j] = w_addr;
                            end
                        end
                        n_cnt = r_cnt + CNTW'(1);
                    end
                end else if (w_out_free) begin
                    w_push  = 1'b1;
                    w_last  = 1'b1;
                    n_state = W_IDLE;
                end
            end
            default: n_state = W_IDLE;
        endcase

        if (w_adv) begin
            n_acc = r_acc + PW'(DEN);
            n_pix = r_pix + PCW'(1);
            n_rem = w_carry ? w_sum - PW'(r_len) : w_sum;
            if (r_major_z) begin
                n_row = r_row + CW'(1);
                if (w_carry) begin
                    n_col = r_col + w_step;
                end
            end else begin
                n_col = r_col + CW'(1);
                if (w_carry) begin
                    n_row = r_row + w_step;
                end
            end
        end

        if (w_push) begin
            n_out_valid        = 1'b1;
            n_out.pixel_addr_a = r_slot[0];
            n_out.pixel_addr_b = r_slot[1];
            n_out.pixel_addr_c = r_slot[2];
            n_out.pixel_addr_d = r_slot[3];
            n_out.valid_count  = 3'(r_cnt);
            n_out.red_out      = r_color.red;
            n_out.green_out    = r_color.green;
            n_out.blue_out     = r_color.blue;
            n_out.last_of_line = w_last;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_major_z <= n_major_z;
        r_len     <= n_len;
        r_neg     <= n_neg;
        r_abs     <= n_abs;
        r_col     <= n_col;
        r_row     <= n_row;
        r_color   <= n_color;
        r_acc     <= n_acc;
        r_rem     <= n_rem;
        r_pix     <= n_pix;
        r_slot    <= n_slot;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= W_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    ap_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == W_WALK) |-> (32'(r_cnt) <= WPR))
        else $error("pixel group count above group size");

    ap_pix_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == W_WALK) |-> (32'(r_pix) <= PIX_CAP))
        else $error("pixel count above cap");

    ap_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == W_WALK && r_len > 0) |-> ($signed({1'b0, r_rem}) < r_len))
        else $error("step remainder out of range");

    ap_mid_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_last) |-> w_full_grp)
        else $error("non-final transaction with partial group");

endmodule

[hdl/line_segment_rasterizer.sv]
// ----------------------------------------------------------------------------
// line_segment_rasterizer
// Rasterizes a world-space line segment into packed pixel write addresses.
// An accepted segment passes multiply, magnitude, reciprocal divide, order,
// classify, queue and walker load before its first walked pixel.
// Setup takes no new segment until it has handed the last one on; the walker
// also stalls on the output, and the two overlap via a two-entry queue.
// Reset clears all control state and sets map_width to 256.
// ----------------------------------------------------------------------------
module line_segment_rasterizer #(
    parameter int WRITES_PER_RESULT = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  rast_pkg::t_in_item   i_item,
    output logic                 empty,
    input  logic                 pop,
    output rast_pkg::t_out_item  o_result,
    input  logic                 i_cfg_we,
    input  logic [8:0]           i_cfg_data
);
    import rast_pkg::*;

    logic [8:0]    r_map_width;
    logic [MW-1:0] w_map_w;
    t_seg          w_setup_seg;
    logic          w_setup_valid;
    logic          w_fifo_full;
    t_seg          w_fifo_seg;
    logic          w_fifo_empty;
    logic          w_fifo_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width <= 9'd256;
        end else if (i_cfg_we) begin
            r_map_width <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_map_width == '0) begin
            w_map_w = MW'(1);
        end else if (32'(r_map_width) > MAP_SIZE) begin
            w_map_w = MW'(MAP_SIZE);
        end else begin
            w_map_w = MW'(r_map_width);
        end
    end

    rast_setup u_setup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .i_map_w     (w_map_w),
        .o_seg_valid (w_setup_valid),
        .i_seg_ready (!w_fifo_full),
        .o_seg       (w_setup_seg)
    );

    rast_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_setup_valid),
        .i_data  (w_setup_seg),
        .o_full  (w_fifo_full),
        .i_pop   (w_fifo_pop),
        .o_data  (w_fifo_seg),
        .o_empty (w_fifo_empty)
    );

    rast_walk #(
        .WPR (WRITES_PER_RESULT)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg_valid (!w_fifo_empty),
        .o_seg_pop   (w_fifo_pop),
        .i_seg       (w_fifo_seg),
        .i_map_w     (w_map_w),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

[sim/tb_line_segment_rasterizer.sv]
// ----------------------------------------------------------------------------
// tb_line_segment_rasterizer
// Checks the line rasterizer against a predictor of its pixel walk. Segments
// go in through the push side and results are compared field by field as
// they are popped, over several map widths and idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_line_segment_rasterizer;
    import rast_pkg::*;

    localparam int WPR      = 4;
    localparam int PIX_CAP  = 64 * WPR;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in_item    i_item;
    logic        empty;
    logic        pop;
    t_out_item   o_result;
    logic        i_cfg_we;
    logic [8:0]  i_cfg_data;

    t_in_item    seg_queue[$];
    t_out_item   expected_results[$];
    logic [8:0]  width_reg;
    int          push_idle_pct;
    int          pop_idle_pct;
    int          error_count;
    int          segs_sent;
    int          results_seen;

    line_segment_rasterizer #(
        .WRITES_PER_RESULT(WPR)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_item(i_item),
        .empty(empty),
        .pop(pop),
        .o_result(o_result),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic longint to_pixel(input logic signed [15:0] w, input longint wid);
        return (longint'(w) + 25600) * wid;
    endfunction

    task automatic rasterize_segment(input t_in_item seg);
        longint wid, sx, sz, ex, ez, t, ddx, ddz, bx, bz, lo, hi, i, col, row;
        int     addrs[$];
        int     nres, p;
        t_out_item r;
        wid = longint'(width_reg);
        if (wid < 1) wid = 1;
        if (wid > MAP_SIZE) wid = MAP_SIZE;
        sx = to_pixel(seg.start_x, wid);
        sz = to_pixel(seg.start_z, wid);
        ex = to_pixel(seg.end_x, wid);
        ez = to_pixel(seg.end_z, wid);
        if (ex < sx) begin
            t = sx; sx = ex; ex = t;
            t = sz; sz = ez; ez = t;
        end
        ddx = ex - sx;
        ddz = ez - sz;
        if (ddx == 0) begin
            bx = ex / 51200;
            if (sz < ez) begin
                lo = sz / 51200; hi = ez / 51200;
            end else begin
                lo = ez / 51200; hi = sz / 51200;
            end
            for (i = lo; i < hi; i++) begin
                if (addrs.size() >= PIX_CAP || bx < 0 || i < 0 || bx >= wid || i >= wid)
                    break;
                addrs.push_back(int'((i * wid + bx) & 16'hFFFF));
            end
        end else if (ddz < ddx && ddz >= -ddx) begin
            bx = sx / 51200;
            bz = sz / 51200;
            for (i = 0; i * 51200 < ddx; i++) begin
                col = i + bx;
                row = (i * ddz) / ddx + bz;
                if (addrs.size() >= PIX_CAP || col < 0 || row < 0 || col >= wid || row >= wid)
                    break;
                addrs.push_back(int'((row * wid + col) & 16'hFFFF));
            end
        end else begin
            if (ez < sz) begin
                t = sx; sx = ex; ex = t;
                t = sz; sz = ez; ez = t;
            end
            ddx = ex - sx;
            ddz = ez - sz;
            bx = sx / 51200;
            bz = sz / 51200;
            for (i = 0; i * 51200 < ddz; i++) begin
                col = (i * ddx) / ddz + bx;
                row = i + bz;
                if (addrs.size() >= PIX_CAP || col < 0 || row < 0 || col >= wid || row >= wid)
                    break;
                addrs.push_back(int'((row * wid + col) & 16'hFFFF));
            end
        end
        nres = (addrs.size() + WPR - 1) / WPR;
        if (nres < 1) nres = 1;
        p = 0;
        for (int k = 0; k < nres; k++) begin
            r = '0;
            for (int j = 0; j < WPR && p < addrs.size(); j++) begin
                case (j)
                    0: r.pixel_addr_a = 16'(addrs[p]);
                    1: r.pixel_addr_b = 16'(addrs[p]);
                    2: r.pixel_addr_c = 16'(addrs[p]);
                    3: r.pixel_addr_d = 16'(addrs[p]);
                    default: ;
                endcase
                p = p + 1;
                r.valid_count = r.valid_count + 3'd1;
            end
            r.red_out = seg.red_in;
            r.green_out = seg.green_in;
            r.blue_out = seg.blue_in;
            r.last_of_line = (k == nres - 1);
            expected_results.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                rasterize_segment(i_item);
                segs_sent <= segs_sent + 1;
            end
            if (!(push && full)) begin
                if (seg_queue.size() > 0 && $urandom_range(99) >= push_idle_pct) begin
                    push <= 1'b1;
                    i_item <= seg_queue.pop_front();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, o_result);
                    error_count <= error_count + 1;
                end else if (expected_results[0] !== o_result) begin
                    $display("%0t: mismatch expected %p actual %p",
                             $time, expected_results[0], o_result);
                    error_count <= error_count + 1;
                    void'(expected_results.pop_front());
                end else begin
                    void'(expected_results.pop_front());
                end
            end
            pop <= ($urandom_range(99) >= pop_idle_pct);
        end
    end

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(9))
            0: return -16'sd25600;
            1: return 16'sd25600;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(51200)) - 25600);
        endcase
    endfunction

    function automatic t_in_item rand_seg();
        t_in_item s;
        s = '0;
        s.start_x = rand_coord();
        s.start_z = rand_coord();
        s.end_x = ($urandom_range(7) == 0) ? s.start_x : rand_coord();
        s.end_z = ($urandom_range(7) == 0) ? s.start_z : rand_coord();
        if ($urandom_range(3) == 0) begin
            s.end_x = s.start_x + 16'($signed($urandom_range(2000)) - 1000);
            s.end_z = s.start_z + 16'($signed($urandom_range(2000)) - 1000);
        end
        s.red_in = 8'($urandom);
        s.green_in = 8'($urandom);
        s.blue_in = 8'($urandom);
        return s;
    endfunction

    function automatic t_in_item make_seg(input int x0, z0, x1, z1, input logic [7:0] c);
        t_in_item s;
        s.start_x = 16'(x0); s.start_z = 16'(z0);
        s.end_x = 16'(x1); s.end_z = 16'(z1);
        s.red_in = c; s.green_in = ~c; s.blue_in = c ^ 8'h5A;
        return s;
    endfunction

    task automatic wait_drained();
        while (seg_queue.size() > 0 || push || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_width(input logic [8:0] w);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= w;
        width_reg = w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [8:0] widths[6];
        widths = '{9'd256, 9'd0, 9'd1, 9'd511, 9'd17, 9'd100};
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        width_reg = 9'd256;
        error_count = 0;
        segs_sent = 0;
        results_seen = 0;
        push_idle_pct = 0;
        pop_idle_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        seg_queue.push_back(make_seg(-25600, -25600, 25600, 25600, 8'h00));
        seg_queue.push_back(make_seg(25600, 25600, -25600, -25600, 8'hFF));
        seg_queue.push_back(make_seg(0, -25600, 0, 25600, 8'h12));
        seg_queue.push_back(make_seg(0, 25600, 0, -25600, 8'h34));
        seg_queue.push_back(make_seg(25600, -25600, 25600, 25600, 8'h56));
        seg_queue.push_back(make_seg(-25600, 0, 25600, 0, 8'h78));
        seg_queue.push_back(make_seg(-25600, 0, 25600, 12000, 8'h9A));
        seg_queue.push_back(make_seg(-25600, 0, 25600, -25600, 8'hBC));
        seg_queue.push_back(make_seg(0, -25600, 1000, 25600, 8'hDE));
        seg_queue.push_back(make_seg(100, 100, 100, 100, 8'h01));
        seg_queue.push_back(make_seg(-32768, -32768, 32767, 32767, 8'h80));
        seg_queue.push_back(make_seg(-32768, 0, 32767, 0, 8'h7F));
        seg_queue.push_back(make_seg(0, -32768, 0, 32767, 8'hA5));
        seg_queue.push_back(make_seg(20000, 20000, 32767, -32768, 8'h3C));
        seg_queue.push_back(make_seg(-1, -1, 1, 1, 8'hC3));
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            set_width(widths[ph]);
            push_idle_pct = (ph % 3 == 0) ? 21 : (ph % 3 == 1) ? 84 : 0;
            pop_idle_pct  = (ph % 3 == 0) ? 84 : (ph % 3 == 1) ? 21 : 0;
            for (int n = 0; n < 58; n++)
                seg_queue.push_back(rand_seg());
            wait_drained();
        end

        $display("Covered %0d segments and %0d results over six map widths.",
                 segs_sent, results_seen);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

[line_segment_rasterizer.f]
hdl/rast_pkg.sv
hdl/rast_setup.sv
hdl/rast_fifo.sv
hdl/rast_walk.sv
hdl/line_segment_rasterizer.sv
sim/tb_line_segment_rasterizer.sv
